// ===== src/bmg_pkg.sv =====
// ----------------------------------------------------------------------------
// bmg_pkg
// Constants, stage schedule and the stage record of the Gaussian generator.
// ----------------------------------------------------------------------------
package bmg_pkg;

    localparam int UNIFORM_BITS  = 16;
    localparam int OUT_FRAC_BITS = 11;
    localparam int SAMPLE_W      = 16;

    localparam int MSB_W = $clog2(UNIFORM_BITS);
    localparam int IP_W  = $clog2(UNIFORM_BITS + 1);

    localparam logic [29:0] LN2_Q30 = 30'h2C5C85FE;
    localparam logic [31:0] PI_Q30  = 32'hC90FDAA2;
    localparam logic [30:0] ONE_Q30 = 31'h40000000;

    // -2 ln x in Q.48 stays below 2^53, so the root has 27 bits
    localparam int RAD2_W      = 54;
    localparam int RAD_W       = 27;
    localparam int LOG_STEPS   = 32;
    localparam int SQRT_STEPS  = RAD_W;
    localparam int COS_STEPS   = 6;
    localparam int SIN_STEPS   = 5;

    // stage schedule; stage 0 is the input register
    localparam int ANGLE_X    = 1;
    localparam int ANGLE_X2   = 2;
    localparam int TRIG_FIRST = 3;
    localparam int SIN_FINAL  = TRIG_FIRST + 2 * SIN_STEPS;
    localparam int TRIG_SEL   = TRIG_FIRST + 2 * COS_STEPS;
    localparam int LN_STAGE   = 1 + LOG_STEPS;
    localparam int SQRT_FIRST = LN_STAGE + 1;
    localparam int MUL_STAGE  = SQRT_FIRST + SQRT_STEPS;
    localparam int OUT_STAGE  = MUL_STAGE + 1;
    localparam int NSTAGE     = OUT_STAGE + 1;

    localparam int RND_SHIFT = 54 - OUT_FRAC_BITS;

    // floor(n / d) = (n * M) >> (31 + S) for any 31-bit n, M = ceil(2^(31+S) / d)
    localparam int COS_SH [COS_STEPS] = '{8, 7, 6, 5, 4, 1};
    localparam logic [32:0] COS_MAG [COS_STEPS] = '{
        33'(((64'd1 << 39) + 64'd131) / 64'd132),
        33'(((64'd1 << 38) + 64'd89) / 64'd90),
        33'(((64'd1 << 37) + 64'd55) / 64'd56),
        33'(((64'd1 << 36) + 64'd29) / 64'd30),
        33'(((64'd1 << 35) + 64'd11) / 64'd12),
        33'(((64'd1 << 32) + 64'd1) / 64'd2)
    };
    localparam int SIN_SH [SIN_STEPS] = '{7, 7, 6, 5, 3};
    localparam logic [32:0] SIN_MAG [SIN_STEPS] = '{
        33'(((64'd1 << 38) + 64'd109) / 64'd110),
        33'(((64'd1 << 38) + 64'd71) / 64'd72),
        33'(((64'd1 << 37) + 64'd41) / 64'd42),
        33'(((64'd1 << 36) + 64'd19) / 64'd20),
        33'(((64'd1 << 34) + 64'd5) / 64'd6)
    };

    typedef struct packed {
        logic                 clamp;
        logic [IP_W-1:0]      ip;
        logic [31:0]          m;
        logic [31:0]          frac;
        logic [RAD2_W-1:0]    v;
        logic [RAD2_W-1:0]    root;
        logic [1:0]           quad;
        logic                 rem_neg;
        logic                 neg;
        logic [29:0]          x;
        logic [29:0]          x2;
        logic [30:0]          ch;
        logic [30:0]          ct;
        logic [30:0]          sh;
        logic [30:0]          st;
        logic [57:0]          prod;
        logic [SAMPLE_W-1:0]  samp;
    } pipe_t;

endpackage

// ===== src/bmg_if.sv =====
// ----------------------------------------------------------------------------
// bmg channels
// Uniform pair in, Gaussian sample out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmg_uniform_if;
    logic                               valid;
    logic                               ready;
    logic [bmg_pkg::UNIFORM_BITS-1:0]   uniform_radius;
    logic [bmg_pkg::UNIFORM_BITS-1:0]   uniform_angle;

    modport source (output valid, output uniform_radius, output uniform_angle, input ready);
    modport sink   (input valid, input uniform_radius, input uniform_angle, output ready);
endinterface

interface bmg_normal_if;
    logic                               valid;
    logic                               ready;
    logic signed [bmg_pkg::SAMPLE_W-1:0] normal_sample;
    logic                               zero_clamped;

    modport source (output valid, output normal_sample, output zero_clamped, input ready);
    modport sink   (input valid, input normal_sample, input zero_clamped, output ready);
endinterface

// ===== src/box_muller_gaussian.sv =====
// ----------------------------------------------------------------------------
// box_muller_gaussian
// Box-Muller Gaussian sample generator, cosine branch, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   uniform : sink channel, one item = two 16-bit uniform fractions
//             (uniform_radius, uniform_angle), each value / 65536.
//   normal  : source channel, one item = normal_sample (signed, 11 fraction
//             bits) and zero_clamped (radius input was zero, taken as 1/65536).
//   Exactly one result item per input item, in order.
// Timing:
//   63 register stages. One item per cycle sustained while the receiver is
//   ready. Depth is set by the 32 squaring steps of the log2 unit plus the 27
//   digit steps of the square root; each log2 stage holds one multiplier and
//   each square root stage one wide compare/subtract.
// Flow control:
//   Each stage has a valid bit; a stage loads when it is empty or the stage
//   after it moves. A stalled receiver holds the output stage, bubbles in
//   front of it still close up and new items are taken until the pipe is full.
// Reset:
//   rst_n clears all valid bits at once; the payload registers are not reset.
// ----------------------------------------------------------------------------
module box_muller_gaussian (
    input  logic           clk,
    input  logic           rst_n,
    bmg_uniform_if.sink    uniform,
    bmg_normal_if.source   normal
);
    import bmg_pkg::*;

    pipe_t st_reg  [NSTAGE];
    pipe_t st_next [NSTAGE];
    logic  vld_reg [NSTAGE];
    logic  stage_ready [NSTAGE];

    // ready chain: a stage may load when it is empty or drains forward
    assign stage_ready[NSTAGE-1] = !vld_reg[NSTAGE-1] || normal.ready;
    for (genvar k = 0; k < NSTAGE - 1; k++) begin : g_rdy
        assign stage_ready[k] = !vld_reg[k] || stage_ready[k+1];
    end

    assign uniform.ready        = stage_ready[0];
    assign normal.valid         = vld_reg[NSTAGE-1];
    assign normal.normal_sample = st_reg[NSTAGE-1].samp;
    assign normal.zero_clamped  = st_reg[NSTAGE-1].clamp;

    // input stage: clamp, normalize the radius, split the angle into quadrants
    always_comb
    begin
        pipe_t                  s;
        logic [UNIFORM_BITS-1:0] u1;
        logic [MSB_W-1:0]       msb;
        logic [31:0]            p;
        logic [32:0]            qs;
        logic [31:0]            rem;
        logic [31:0]            a;
        s       = '0;
        u1      = uniform.uniform_radius;
        s.clamp = (u1 == '0);
        if (s.clamp)
        begin
            u1 = UNIFORM_BITS'(1);
        end
        msb = '0;
        for (int i = 0; i < UNIFORM_BITS; i++)
        begin
            if (u1[i])
            begin
                msb = MSB_W'(i);
            end
        end
        s.m  = 32'(u1) << (6'd31 - 6'(msb));
        s.ip = IP_W'(UNIFORM_BITS) - IP_W'(msb);
        p    = 32'(uniform.uniform_angle) << (32 - UNIFORM_BITS);
        qs   = {1'b0, p} + 33'(32'h20000000);
        s.quad    = qs[31:30];
        rem       = p - {s.quad, 30'b0};
        s.rem_neg = rem[31];
        a         = s.rem_neg ? (32'd0 - rem) : rem;
        s.x       = a[29:0];
        st_next[0] = s;
    end

    for (genvar k = 1; k < NSTAGE; k++) begin : g_stage
        localparam int K    = k;
        localparam int FB   = (K <= LOG_STEPS) ? (LOG_STEPS - K) : 0;
        localparam int CRAW = (K >= TRIG_FIRST) ? ((K - TRIG_FIRST) / 2) : 0;
        localparam int CI   = (CRAW > COS_STEPS - 1) ? (COS_STEPS - 1) : CRAW;
        localparam int SI   = (CRAW > SIN_STEPS - 1) ? (SIN_STEPS - 1) : CRAW;
        localparam int SB   = (K >= SQRT_FIRST && K < MUL_STAGE) ?
                              (2 * (SQRT_STEPS - 1 - (K - SQRT_FIRST))) : 0;

        always_comb
        begin
            pipe_t                 s;
            logic [63:0]           pm;
            logic [32:0]           sq;
            logic [IP_W+31:0]      lval;
            logic [63:0]           pl;
            logic [RAD2_W-1:0]     sbit;
            logic [RAD2_W-1:0]     ssum;
            logic [63:0]           pd;
            logic [63:0]           pe;
            logic [58:0]           rnd;
            logic [16:0]           mag;
            logic [16:0]           lim;
            s    = st_reg[k-1];
            pm   = '0;
            sq   = '0;
            lval = '0;
            pl   = '0;
            sbit = '0;
            ssum = '0;
            pd   = '0;
            pe   = '0;
            rnd  = '0;
            mag  = '0;
            lim  = '0;

            // log2 by repeated squaring, one fraction bit per stage
            if (K >= 1 && K <= LOG_STEPS)
            begin
                pm = {32'b0, s.m} * {32'b0, s.m};
                sq = pm[63:31];
                if (sq[32])
                begin
                    s.m        = sq[32:1];
                    s.frac[FB] = 1'b1;
                end
                else
                begin
                    s.m = sq[31:0];
                end
            end

            // scale -log2 to -2 ln
            if (K == LN_STAGE)
            begin
                lval   = {s.ip, 32'b0} - {IP_W'(0), s.frac};
                pl     = 64'(lval[IP_W+31:4]) * 64'(LN2_Q30);
                s.v    = pl[62:9];
                s.root = '0;
            end

            // square root, one result bit per stage
            if (K >= SQRT_FIRST && K < MUL_STAGE)
            begin
                sbit = RAD2_W'(1) << SB;
                ssum = s.root + sbit;
                if (s.v >= ssum)
                begin
                    s.v    = s.v - ssum;
                    s.root = (s.root >> 1) + sbit;
                end
                else
                begin
                    s.root = s.root >> 1;
                end
            end

            // angle to radians and its square
            if (K == ANGLE_X)
            begin
                pd  = 64'(s.x) * 64'(PI_Q30);
                s.x = pd[60:31];
            end
            if (K == ANGLE_X2)
            begin
                pd   = 64'(s.x) * 64'(s.x);
                s.x2 = pd[59:30];
                s.ch = ONE_Q30;
                s.sh = ONE_Q30;
            end

            // Horner steps: multiply stage, then divide by reciprocal stage
            if (K >= TRIG_FIRST && K < TRIG_SEL && ((K - TRIG_FIRST) % 2) == 0)
            begin
                pd   = 64'(s.x2) * 64'(s.ch);
                s.ct = pd[60:30];
                if (K < SIN_FINAL)
                begin
                    pe   = 64'(s.x2) * 64'(s.sh);
                    s.st = pe[60:30];
                end
            end
            if (K >= TRIG_FIRST && K < TRIG_SEL && ((K - TRIG_FIRST) % 2) == 1)
            begin
                pd   = 64'(s.ct) * 64'(COS_MAG[CI]);
                s.ch = ONE_Q30 - 31'(pd >> (31 + COS_SH[CI]));
                if (K < SIN_FINAL)
                begin
                    pe   = 64'(s.st) * 64'(SIN_MAG[SI]);
                    s.sh = ONE_Q30 - 31'(pe >> (31 + SIN_SH[SI]));
                end
            end
            if (K == SIN_FINAL)
            begin
                pe   = 64'(s.x) * 64'(s.sh);
                s.sh = pe[60:30];
            end

            // pick +-cos or +-sin by quadrant
            if (K == TRIG_SEL)
            begin
                case (s.quad)
                    2'd0:
                    begin
                        s.neg = 1'b0;
                    end
                    2'd1:
                    begin
                        s.ch  = s.sh;
                        s.neg = !s.rem_neg;
                    end
                    2'd2:
                    begin
                        s.neg = 1'b1;
                    end
                    default:
                    begin
                        s.ch  = s.sh;
                        s.neg = s.rem_neg;
                    end
                endcase
            end

            if (K == MUL_STAGE)
            begin
                pd     = 64'(s.root[RAD_W-1:0]) * 64'(s.ch);
                s.prod = pd[57:0];
            end

            // round half away from zero, saturate, apply sign
            if (K == OUT_STAGE)
            begin
                rnd = {1'b0, s.prod} + (59'(1) << (RND_SHIFT - 1));
                mag = 17'(rnd >> RND_SHIFT);
                lim = s.neg ? 17'd32768 : 17'd32767;
                if (mag > lim)
                begin
                    mag = lim;
                end
                s.samp = s.neg ? SAMPLE_W'(17'd0 - mag) : mag[SAMPLE_W-1:0];
            end

            st_next[k] = s;
        end
    end

    for (genvar k = 0; k < NSTAGE; k++) begin : g_reg
        logic vld_in;
        if (k == 0) begin : g_first
            assign vld_in = uniform.valid;
        end
        else begin : g_rest
            assign vld_in = vld_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (stage_ready[k])
            begin
                vld_reg[k] <= vld_in;
            end
        end

        // hold payload while stalled or empty
        always_ff @(posedge clk)
        begin
            if (stage_ready[k] && vld_in)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

endmodule

// ===== src/bmg_checker.sv =====
// ----------------------------------------------------------------------------
// bmg_checker
// Port-level checks on the Gaussian generator, bound to the top level.
// ----------------------------------------------------------------------------
module bmg_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [bmg_pkg::SAMPLE_W-1:0]  sample,
    input logic                                 clamped
);
    import bmg_pkg::*;

    // hold the offered item until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sample) && $stable(clamped))
        else $error("stalled result item changed");

    // empty output stage means every stage can advance
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output stage");

    // radius never exceeds sqrt(32 ln 2), so the sample stays well inside range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample <= 16'sd9700) && (sample >= -16'sd9700))
        else $error("sample magnitude out of range");

endmodule

bind box_muller_gaussian bmg_checker u_bmg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (uniform.valid),
    .in_ready  (uniform.ready),
    .out_valid (normal.valid),
    .out_ready (normal.ready),
    .sample    (normal.normal_sample),
    .clamped   (normal.zero_clamped)
);

// ===== verif/box_muller_gaussian_tb.sv =====
// ----------------------------------------------------------------------------
// box_muller_gaussian_tb
// Drives uniform pairs into the Gaussian generator and checks every sample
// against a bit-accurate fixed-point model kept in the bench.
// ----------------------------------------------------------------------------
module box_muller_gaussian_tb;

    import bmg_pkg::*;

    localparam int LIMIT_CYCLES = 200000;

    typedef struct {
        logic [UNIFORM_BITS-1:0] radius;
        logic [UNIFORM_BITS-1:0] angle;
    } pair_t;

    typedef struct {
        logic [SAMPLE_W-1:0] samp;
        logic                clamped;
    } gauss_t;

    logic clk;
    logic rst_n;

    bmg_uniform_if uniform ();
    bmg_normal_if  normal ();

    box_muller_gaussian u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .uniform (uniform.sink),
        .normal  (normal.source)
    );

    pair_t  pending_pairs[$];
    gauss_t expected_samples[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_off      = 0;
    int  errors        = 0;
    int  cycles        = 0;

    // Clock: period 10.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Fixed-point Gaussian model.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // -log2 of u / 2^UNIFORM_BITS in Q.32; u nonzero
    function automatic logic [63:0] neg_log2(logic [63:0] u);
        int          msb;
        logic [63:0] m;
        logic [63:0] frac;
        msb  = 0;
        frac = 0;
        for (int i = 0; i < 32; i++)
            if (u[i])
                msb = i;
        m = (u << (31 - msb)) & 64'hFFFF_FFFF;
        for (int i = 0; i < 32; i++)
        begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32))
            begin
                m = m >> 1;
                frac[31 - i] = 1'b1;
            end
        end
        return (64'(UNIFORM_BITS - msb) << 32) - frac;
    endfunction

    // Horner series: cos through x^12, or sin factor through x^10
    function automatic logic [63:0] horner(logic [63:0] x2, bit is_sin);
        logic [63:0] h;
        int          nsteps;
        logic [63:0] d;
        h      = 64'd1 << 30;
        nsteps = is_sin ? 5 : 6;
        for (int i = 0; i < nsteps; i++)
        begin
            if (is_sin)
                d = (i == 0) ? 110 : (i == 1) ? 72 : (i == 2) ? 42 : (i == 3) ? 20 : 6;
            else
                d = (i == 0) ? 132 : (i == 1) ? 90 : (i == 2) ? 56 : (i == 3) ? 30
                  : (i == 4) ? 12 : 2;
            h = (64'd1 << 30) - ((x2 * h) >> 30) / d;
        end
        return h;
    endfunction

    function automatic gauss_t predict_gauss(pair_t p_in);
        gauss_t      res;
        logic [63:0] u1, u2, l, r48, rad, p, rem, a, x, x2, trig, mag, lim;
        logic [127:0] prod;
        logic [1:0]  q;
        bit          rem_neg, neg;
        u1 = 64'(p_in.radius);
        u2 = 64'(p_in.angle);
        res.clamped = (u1 == 0);
        if (u1 == 0)
            u1 = 1;
        l   = neg_log2(u1);
        r48 = ((l >> 4) * 64'h2C5C85FE) >> 9;
        rad = root_floor(r48);

        p   = (u2 << (32 - UNIFORM_BITS)) & 64'hFFFF_FFFF;
        q   = 2'(((p + (64'd1 << 29)) >> 30) & 3);
        rem = (p - (64'(q) << 30)) & 64'hFFFF_FFFF;
        rem_neg = rem[31];
        a   = rem_neg ? ((64'h1_0000_0000 - rem) & 64'hFFFF_FFFF) : rem;
        x   = (a * 64'hC90FDAA2) >> 31;
        x2  = (x * x) >> 30;

        case (q)
            2'd0: begin trig = horner(x2, 0); neg = 0; end
            2'd1: begin trig = (x * horner(x2, 1)) >> 30; neg = !rem_neg; end
            2'd2: begin trig = horner(x2, 0); neg = 1; end
            default: begin trig = (x * horner(x2, 1)) >> 30; neg = rem_neg; end
        endcase

        prod = 128'(rad) * 128'(trig);
        mag  = 64'((prod + (128'd1 << (RND_SHIFT - 1))) >> RND_SHIFT);
        lim  = neg ? 64'd32768 : 64'd32767;
        if (mag > lim)
            mag = lim;
        res.samp = neg ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer the head of the pending queue, idling at random.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uniform.valid          <= 1'b0;
            uniform.uniform_radius <= '0;
            uniform.uniform_angle  <= '0;
        end
        else
        begin
            // item accepted: drop it and predict its sample
            if (uniform.valid && uniform.ready)
            begin
                expected_samples.push_back(predict_gauss(pending_pairs.pop_front()));
            end
            if ((!uniform.valid || uniform.ready) && pending_pairs.size() > 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                uniform.valid          <= 1'b1;
                uniform.uniform_radius <= pending_pairs[0].radius;
                uniform.uniform_angle  <= pending_pairs[0].angle;
            end
            else if (uniform.ready)
                uniform.valid <= 1'b0;
        end
    end

    // Hold-off counter: count down the cycles the receiver stays closed.
    always @(posedge clk)
    begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted sample, then pick the next ready.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            normal.ready <= 1'b0;
        else
        begin
            if (normal.valid && normal.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected sample %0d clamp %0b", $time,
                             normal.normal_sample, normal.zero_clamped);
                    errors++;
                end
                else
                begin
                    gauss_t exp_s;
                    exp_s = expected_samples.pop_front();
                    if (normal.normal_sample !== exp_s.samp)
                    begin
                        $display("%0t: sample expected %0d actual %0d", $time,
                                 $signed(exp_s.samp), normal.normal_sample);
                        errors++;
                    end
                    if (normal.zero_clamped !== exp_s.clamped)
                    begin
                        $display("%0t: clamp flag expected %0b actual %0b", $time,
                                 exp_s.clamped, normal.zero_clamped);
                        errors++;
                    end
                end
            end
            if (hold_off > 0)
                normal.ready <= 1'b0;
            else
                normal.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic add_pair(logic [UNIFORM_BITS-1:0] r, logic [UNIFORM_BITS-1:0] a);
        pair_t p;
        p.radius = r;
        p.angle  = a;
        pending_pairs.push_back(p);
    endtask

    // Random pair; now and then bias the radius toward tiny values, to hit the
    // steep end of the log, or toward values near full scale.
    task automatic add_random(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: add_pair(UNIFORM_BITS'($urandom_range(3)), UNIFORM_BITS'($urandom));
                1: add_pair(UNIFORM_BITS'($urandom_range(65535, 65000)),
                            UNIFORM_BITS'($urandom));
                default: add_pair(UNIFORM_BITS'($urandom), UNIFORM_BITS'($urandom));
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || uniform.valid)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: radius extremes and the zero clamp, angles at each
        // quarter turn and on both sides of the octant boundaries.
        add_pair(16'h0000, 16'h0000);
        add_pair(16'h0000, 16'h8000);
        add_pair(16'h0001, 16'h0000);
        add_pair(16'h0001, 16'h8000);
        add_pair(16'hFFFF, 16'h0000);
        add_pair(16'hFFFF, 16'hFFFF);
        add_pair(16'h8000, 16'h4000);
        add_pair(16'h8000, 16'hC000);
        add_pair(16'h5555, 16'h1FFF);
        add_pair(16'h5555, 16'h2000);
        add_pair(16'hAAAA, 16'h5FFF);
        add_pair(16'hAAAA, 16'h6000);
        add_pair(16'h0100, 16'h9FFF);
        add_pair(16'h0100, 16'hA000);
        add_pair(16'h7FFF, 16'hDFFF);
        add_pair(16'h7FFF, 16'hE000);
        add_pair(16'h0002, 16'h2AAA);
        add_pair(16'h0000, 16'hFFFF);

        // Sender idles less often than the receiver first.
        send_idle_pct = 19;
        recv_idle_pct = 68;
        add_random(130);
        wait_drained();

        send_idle_pct = 68;
        recv_idle_pct = 19;
        add_random(80);
        wait_drained();

        // No idling; a long receiver hold-off while the sender keeps
        // offering fills the pipe.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off      = 150;
        add_random(190);
        wait_drained();

        while (expected_samples.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
